// ===== rtl/core/tkmh_pkg.sv =====
// Shared types and constants of the top-K min-heap filter
`timescale 1ns / 1ps

package tkmh_pkg;

   localparam int HEAP_DEPTH_DEFAULT = 512;
   localparam int CAP_W              = 10;
   localparam int FILL_W             = 10;
   localparam int KEY_W              = 32;
   localparam int TAG_W              = 32;
   localparam int ENTRY_W            = KEY_W + TAG_W;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(400);

   localparam logic [1:0] REQ_INSERT  = 2'd0;
   localparam logic [1:0] REQ_EXTRACT = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;
   localparam logic [1:0] REQ_UNUSED  = 2'd3;

   localparam logic [2:0] ST_APPENDED  = 3'd0;
   localparam logic [2:0] ST_DROPPED   = 3'd1;
   localparam logic [2:0] ST_REPLACED  = 3'd2;
   localparam logic [2:0] ST_EXTRACTED = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_CLEARED   = 3'd5;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [TAG_W-1:0] entry_tag;
      logic [KEY_W-1:0] entry_count;
   } req_data_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [TAG_W-1:0]  out_tag;
      logic [KEY_W-1:0]  out_count;
      logic [FILL_W-1:0] fill;
   } rsp_data_type;

   typedef struct packed {
      logic [KEY_W-1:0] count;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

// ===== rtl/core/tkmh_ram.sv =====
// Generic RAM: one write port, two registered read ports
`timescale 1ns / 1ps

module tkmh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
   end

endmodule

// ===== rtl/core/top_k_min_heap_filter_core.sv =====
// Top-K min-heap filter: keeps the largest-count entries in a binary min-heap held in RAM
`timescale 1ns / 1ps

// One request is taken at a time and answered by exactly one response transfer. The heap
// lives in a RAM with two registered read ports; the entry being moved is held in a
// register, and each sift level is a read state, then a compare and write-back state.
// A request passes through the root read and dispatch states, an optional sift up or down,
// and the response state, which waits while the previous response is still not taken. A new
// request may be taken while the previous response still waits in the output register.
// Capacity is clamped to 1 .. HEAP_DEPTH; the user must write it only while the block is
// idle, as the block itself does not enforce this.

module top_k_min_heap_filter_core #(
   parameter int HEAP_DEPTH = tkmh_pkg::HEAP_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tkmh_pkg::req_data_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tkmh_pkg::rsp_data_type      rsp_data,
   input  logic                        csr_we,
   input  logic [tkmh_pkg::CAP_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int IW = (AW + 2 > tkmh_pkg::FILL_W + 1) ? AW + 2 : tkmh_pkg::FILL_W + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_ROOT, S_DISPATCH, S_UP_RD, S_UP_CMP, S_DOWN_RD, S_DOWN_CMP, S_RESP
   } state_type;

   state_type                      state_ff, state_in;
   logic [tkmh_pkg::CAP_W-1:0]     cap_ff, cap_in;
   logic [tkmh_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tkmh_pkg::req_data_type         req_ff, req_in;
   tkmh_pkg::entry_type            hold_ff, hold_in;
   logic [AW-1:0]                  pos_ff, pos_in;
   logic [IW-1:0]                  kid_ff, kid_in;
   logic [IW-1:0]                  lim_ff, lim_in;
   tkmh_pkg::rsp_data_type         res_ff, res_in;
   tkmh_pkg::rsp_data_type         rsp_ff, rsp_in;

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr, ram_ra, ram_rb;
   tkmh_pkg::entry_type            ram_wdata;
   logic [tkmh_pkg::ENTRY_W-1:0]   ram_rd_a, ram_rd_b;
   tkmh_pkg::entry_type            ent_a, ent_b, child;

   logic [IW-1:0]                  fill_ix, cap_ix, eff_cap, pos_ix, kid_nx, cidx;
   logic                           pick_right;

   tkmh_ram #(
      .WIDTH (tkmh_pkg::ENTRY_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_a_addr (ram_ra),
      .rd_a_data (ram_rd_a),
      .rd_b_addr (ram_rb),
      .rd_b_data (ram_rd_b)
   );

   assign ent_a     = tkmh_pkg::entry_type'(ram_rd_a);
   assign ent_b     = tkmh_pkg::entry_type'(ram_rd_b);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign fill_ix = IW'(fill_ff);
   assign cap_ix  = IW'(cap_ff);
   assign pos_ix  = IW'(pos_ff);
   assign kid_nx  = kid_ff + IW'(1);

   always_comb begin
      if (cap_ix == '0) begin
         eff_cap = IW'(1);
      end else if (cap_ix > IW'(HEAP_DEPTH)) begin
         eff_cap = IW'(HEAP_DEPTH);
      end else begin
         eff_cap = cap_ix;
      end
   end

   always_comb begin
      pick_right = (kid_nx < lim_ff) && (ent_a.count > ent_b.count);
      child      = pick_right ? ent_b : ent_a;
      cidx       = pick_right ? kid_nx : kid_ff;
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_in       = req_ff;
      hold_in      = hold_ff;
      pos_in       = pos_ff;
      kid_in       = kid_ff;
      lim_in       = lim_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = hold_ff;
      ram_ra       = '0;
      ram_rb       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            ram_ra   = '0;
            ram_rb   = AW'(fill_ix - IW'(1));
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            res_in = '{status: tkmh_pkg::ST_DROPPED, out_tag: '0, out_count: '0,
                       fill: fill_ff};
            state_in = S_RESP;
            case (req_ff.req_type)
               tkmh_pkg::REQ_INSERT: begin
                  if (fill_ix < eff_cap) begin
                     hold_in       = '{count: req_ff.entry_count, tag: req_ff.entry_tag};
                     pos_in        = AW'(fill_ix);
                     fill_in       = fill_ff + tkmh_pkg::FILL_W'(1);
                     res_in.status = tkmh_pkg::ST_APPENDED;
                     res_in.fill   = fill_ff + tkmh_pkg::FILL_W'(1);
                     state_in      = S_UP_RD;
                  end else if (req_ff.entry_count >= ent_a.count) begin
                     hold_in       = '{count: req_ff.entry_count, tag: req_ff.entry_tag};
                     pos_in        = '0;
                     kid_in        = IW'(1);
                     lim_in        = fill_ix;
                     res_in.status = tkmh_pkg::ST_REPLACED;
                     state_in      = S_DOWN_RD;
                  end
               end
               tkmh_pkg::REQ_EXTRACT: begin
                  if (fill_ff == '0) begin
                     res_in.status = tkmh_pkg::ST_EMPTY;
                  end else begin
                     hold_in          = ent_b;
                     pos_in           = '0;
                     kid_in           = IW'(1);
                     lim_in           = fill_ix - IW'(1);
                     fill_in          = fill_ff - tkmh_pkg::FILL_W'(1);
                     res_in.status    = tkmh_pkg::ST_EXTRACTED;
                     res_in.out_tag   = ent_a.tag;
                     res_in.out_count = ent_a.count;
                     res_in.fill      = fill_ff - tkmh_pkg::FILL_W'(1);
                     state_in         = S_DOWN_RD;
                  end
               end
               tkmh_pkg::REQ_CLEAR: begin
                  fill_in       = '0;
                  res_in.status = tkmh_pkg::ST_CLEARED;
                  res_in.fill   = '0;
               end
               default: begin
               end
            endcase
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = S_RESP;
            end else begin
               ram_ra   = AW'((pos_ix - IW'(1)) >> 1);
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            ram_we = 1'b1;
            if (ent_a.count > hold_ff.count) begin
               ram_wdata = ent_a;
               pos_in    = AW'((pos_ix - IW'(1)) >> 1);
               state_in  = S_UP_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_DOWN_RD: begin
            if (kid_ff < lim_ff) begin
               ram_ra   = AW'(kid_ff);
               ram_rb   = AW'(kid_nx);
               state_in = S_DOWN_CMP;
            end else begin
               ram_we   = 1'b1;
               state_in = S_RESP;
            end
         end
         S_DOWN_CMP: begin
            ram_we = 1'b1;
            if (hold_ff.count > child.count) begin
               ram_wdata = child;
               pos_in    = AW'(cidx);
               kid_in    = (cidx << 1) + IW'(1);
               state_in  = S_DOWN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= tkmh_pkg::CAPACITY_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      hold_ff <= hold_in;
      pos_ff  <= pos_in;
      kid_ff  <= kid_in;
      lim_ff  <= lim_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule
